// ===== hdl/lgs_pkg.sv =====
package lgs_pkg;

  localparam int GRID_ROWS = 24;
  localparam int GRID_COLS = 80;

  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int DEPTH  = 2 * GRID_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);

  // step sequencer counts GRID_ROWS + 2 row reads and must hold that count
  localparam int STEP_CNT_W = $clog2(GRID_ROWS + 3);

  // result queue
  localparam int OUT_DEPTH = 3;
  localparam int OQ_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OQ_CNT_W  = $clog2(OUT_DEPTH + 1);

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_STEP  = 2'd2;

  typedef logic [GRID_COLS-1:0] row_t;

endpackage

// ===== hdl/lgs_ram.sv =====
module lgs_ram #(
  parameter int DEPTH  = 48,
  parameter int DATA_W = 80,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [DATA_W-1:0] wmask,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < DATA_W; i++) begin
        if (wmask[i]) begin
          mem[waddr][i] <= wdata[i];
        end
      end
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/lgs_gen.sv =====
module lgs_gen (
  input  lgs_pkg::row_t up,
  input  lgs_pkg::row_t mid,
  input  lgs_pkg::row_t dn,
  output lgs_pkg::row_t nxt
);

  // one lane per column, neighbors wrap at the row ends
  always_comb begin
    int l;
    int r;
    logic [3:0] n;
    nxt = '0;
    for (int c = 0; c < lgs_pkg::GRID_COLS; c++) begin
      l = (c == 0) ? lgs_pkg::GRID_COLS - 1 : c - 1;
      r = (c == lgs_pkg::GRID_COLS - 1) ? 0 : c + 1;
      n = 4'(up[l]) + 4'(up[c]) + 4'(up[r]) + 4'(mid[l]) + 4'(mid[r])
        + 4'(dn[l]) + 4'(dn[c]) + 4'(dn[r]);
      nxt[c] = (n == 4'd3) | (mid[c] & (n == 4'd2));
    end
  end

endmodule

// ===== hdl/lgs_out_fifo.sv =====
module lgs_out_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic                         push_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_data,
  output logic [lgs_pkg::OQ_CNT_W-1:0] count
);

  logic [lgs_pkg::OUT_DEPTH-1:0] data_r;
  logic [lgs_pkg::OQ_PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [lgs_pkg::OQ_PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [lgs_pkg::OQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                          pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = data_r[rptr_r];
  assign count     = cnt_r;
  assign pop       = out_valid & out_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == lgs_pkg::OQ_PTR_W'(lgs_pkg::OUT_DEPTH - 1)) ? '0
                 : wptr_r + lgs_pkg::OQ_PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == lgs_pkg::OQ_PTR_W'(lgs_pkg::OUT_DEPTH - 1)) ? '0
                 : rptr_r + lgs_pkg::OQ_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + lgs_pkg::OQ_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - lgs_pkg::OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) begin
      data_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/life_generation_step.sv =====
// cell write: one per cycle while in_ready is high (block idle, result queue not full), no result
// cell read: one per cycle while in_ready is high; the result passes pend_r and the result queue before out_valid
// step: occupies the block while it does one grid-row read per cycle from the row memory
//   and fills the pipeline of the row window; in_ready stays low meanwhile
// reset: rst_n synchronous active low; a clearing pass then zeroes all 2 * GRID_ROWS rows
//   of both buffers, in_ready stays low meanwhile
module life_generation_step (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_func,
  input  logic [4:0]                in_row,
  input  logic [6:0]                in_column,
  input  logic                      in_cell_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_cell_out
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_STEP} state_t;

  localparam int AW = lgs_pkg::ADDR_W;
  localparam int RW = lgs_pkg::ROW_W;
  localparam int CW = lgs_pkg::COL_W;
  localparam int SW = lgs_pkg::STEP_CNT_W;
  localparam int QW = lgs_pkg::OQ_CNT_W + 1;

  state_t                 state_r, state_nxt;
  logic                   sel_r, sel_nxt;
  logic [AW-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [SW-1:0]          rd_cnt_r, rd_cnt_nxt;
  logic                   rv_r, rv_nxt;
  logic [SW-1:0]          rk_r, rk_nxt;
  lgs_pkg::row_t          win0_r, win1_r;
  logic                   pend_r, pend_nxt;
  logic                   pend_in_r;
  logic [CW-1:0]          pend_col_r;

  logic                   acc;
  logic                   on_grid;
  logic [RW-1:0]          row_idx;
  logic [CW-1:0]          col_idx;
  logic [RW-1:0]          step_row;

  logic                   we;
  logic [AW-1:0]          waddr;
  lgs_pkg::row_t          wdata;
  lgs_pkg::row_t          wmask;
  logic [AW-1:0]          raddr;
  lgs_pkg::row_t          rdata;
  lgs_pkg::row_t          nxt_row;
  logic [lgs_pkg::OQ_CNT_W-1:0] q_cnt;

  function automatic logic [AW-1:0] buf_addr(input logic b, input logic [RW-1:0] r);
    logic [AW-1:0] base;
    base = b ? AW'(lgs_pkg::GRID_ROWS) : AW'(0);
    return AW'(r) + base;
  endfunction

  assign on_grid = (int'(in_row) < lgs_pkg::GRID_ROWS) && (int'(in_column) < lgs_pkg::GRID_COLS);
  assign row_idx = on_grid ? RW'(in_row) : '0;
  assign col_idx = on_grid ? CW'(in_column) : '0;

  // space for the read in flight plus the queued results
  assign in_ready = (state_r == ST_IDLE) && ((QW'(q_cnt) + QW'(pend_r)) < QW'(lgs_pkg::OUT_DEPTH));
  assign acc      = in_valid & in_ready;

  // source rows in order: last, 0, 1, ..., last, 0
  always_comb begin
    if (rd_cnt_r == '0) begin
      step_row = RW'(lgs_pkg::GRID_ROWS - 1);
    end else if (rd_cnt_r == SW'(lgs_pkg::GRID_ROWS + 1)) begin
      step_row = '0;
    end else begin
      step_row = RW'(rd_cnt_r - SW'(1));
    end
  end

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    clr_cnt_nxt = clr_cnt_r;
    rd_cnt_nxt  = rd_cnt_r;
    rv_nxt      = 1'b0;
    rk_nxt      = rd_cnt_r;
    pend_nxt    = 1'b0;
    we          = 1'b0;
    waddr       = buf_addr(sel_r, row_idx);
    wdata       = {lgs_pkg::GRID_COLS{in_cell_in}};
    wmask       = lgs_pkg::row_t'(1) << col_idx;
    raddr       = buf_addr(sel_r, row_idx);
    case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt_r;
        wdata = '0;
        wmask = '1;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(lgs_pkg::DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          case (in_func)
            lgs_pkg::FUNC_WRITE: we = on_grid;
            lgs_pkg::FUNC_READ:  pend_nxt = 1'b1;
            lgs_pkg::FUNC_STEP: begin
              state_nxt  = ST_STEP;
              rd_cnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_STEP: begin
        raddr = buf_addr(sel_r, step_row);
        if (rd_cnt_r <= SW'(lgs_pkg::GRID_ROWS + 1)) begin
          rv_nxt     = 1'b1;
          rd_cnt_nxt = rd_cnt_r + SW'(1);
        end
        // window holds rows above and at center, memory output is the row below
        if (rv_r && (rk_r >= SW'(2))) begin
          we    = 1'b1;
          waddr = buf_addr(~sel_r, RW'(rk_r - SW'(2)));
          wdata = nxt_row;
          wmask = '1;
        end
        if (rv_r && (rk_r == SW'(lgs_pkg::GRID_ROWS + 1))) begin
          state_nxt  = ST_IDLE;
          sel_nxt    = ~sel_r;
          rd_cnt_nxt = '0;
          rv_nxt     = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      sel_r     <= 1'b0;
      clr_cnt_r <= '0;
      rd_cnt_r  <= '0;
      rv_r      <= 1'b0;
      rk_r      <= '0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sel_r     <= sel_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      rv_r      <= rv_nxt;
      rk_r      <= rk_nxt;
      pend_r    <= pend_nxt;
    end
    if (rv_r) begin
      win0_r <= win1_r;
      win1_r <= rdata;
    end
    if (acc) begin
      pend_in_r  <= on_grid;
      pend_col_r <= col_idx;
    end
  end

  lgs_ram #(
    .DEPTH (lgs_pkg::DEPTH),
    .DATA_W(lgs_pkg::GRID_COLS),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .wmask(wmask),
    .raddr(raddr),
    .rdata(rdata)
  );

  lgs_gen u_gen (
    .up (win0_r),
    .mid(win1_r),
    .dn (rdata),
    .nxt(nxt_row)
  );

  lgs_out_fifo u_oq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (pend_r),
    .push_data(pend_in_r & rdata[pend_col_r]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_cell_out),
    .count    (q_cnt)
  );

endmodule

// ===== hdl/lgs_checker.sv =====
module lgs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_cell_out
);

  // clearing pass keeps input closed right after reset
  a_clear_closed: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_ready high during clearing pass");

  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // a step beat stalls the input while the grid is walked
  a_step_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == lgs_pkg::FUNC_STEP) |=> !in_ready)
    else $error("input open right after step beat");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == lgs_pkg::FUNC_READ) |=> ##1 out_valid)
    else $error("read beat gave no result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_cell_out)))
    else $error("stalled result beat changed");

endmodule

bind life_generation_step lgs_checker u_lgs_checker (.*);

// ===== dv/life_generation_step_tb.sv =====
`timescale 1ns / 1ps

module life_generation_step_tb;
  import lgs_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [4:0] row;
    logic [6:0] col;
    logic       alive;
  } cell_read_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_func;
  logic [4:0] in_row;
  logic [6:0] in_column;
  logic       in_cell_in;
  logic       out_valid;
  logic       out_ready;
  logic       out_cell_out;

  // shadow of both buffers plus the current-buffer pointer
  bit         life_cells [2][GRID_ROWS][GRID_COLS];
  bit         live_sel;
  cell_read_t pending_reads[$];
  cell_read_t head_read;

  int mismatches;
  int items_sent;
  int reads_checked;
  int generations_run;
  int send_max_gap;
  int recv_max_stall;
  int ready_wait;
  int hold_cycles;
  int win_row;
  int win_col;

  life_generation_step dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_row      (in_row),
    .in_column   (in_column),
    .in_cell_in  (in_cell_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_cell_out(out_cell_out)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(string what, cell_read_t rd, logic got);
    $display("%0t ns mismatch: %s at row %0d column %0d, expected %0b got %0b",
             $time, what, rd.row, rd.col, rd.alive, got);
    mismatches++;
  endtask

  function automatic void advance_generation();
    int up;
    int dn;
    int lf;
    int rt;
    int n;
    bit src;
    src = live_sel;
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        up = (r + GRID_ROWS - 1) % GRID_ROWS;
        dn = (r + 1) % GRID_ROWS;
        lf = (c + GRID_COLS - 1) % GRID_COLS;
        rt = (c + 1) % GRID_COLS;
        n = life_cells[src][up][lf] + life_cells[src][up][c] + life_cells[src][up][rt]
          + life_cells[src][r][lf] + life_cells[src][r][rt]
          + life_cells[src][dn][lf] + life_cells[src][dn][c] + life_cells[src][dn][rt];
        if (life_cells[src][r][c])
          life_cells[!src][r][c] = (n == 2 || n == 3);
        else
          life_cells[!src][r][c] = (n == 3);
      end
    end
    live_sel = !live_sel;
    generations_run++;
  endfunction

  function automatic void predict_cell_item(logic [1:0] func, logic [4:0] row,
                                            logic [6:0] col, logic val);
    bit         on_grid;
    cell_read_t rd;
    on_grid = (row < GRID_ROWS) && (col < GRID_COLS);
    case (func)
      FUNC_WRITE: begin
        if (on_grid) life_cells[live_sel][row][col] = val;
      end
      FUNC_READ: begin
        rd.row = row;
        rd.col = col;
        rd.alive = on_grid ? life_cells[live_sel][row][col] : 1'b0;
        pending_reads.push_back(rd);
      end
      FUNC_STEP: begin
        advance_generation();
      end
      default: ;
    endcase
  endfunction

  task automatic send_cell_item(logic [1:0] func, logic [4:0] row, logic [6:0] col,
                                logic val);
    int gap;
    gap = $urandom_range(0, send_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func = func;
    in_row = row;
    in_column = col;
    in_cell_in = val;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_cell_item(func, row, col, val);
    items_sent++;
  endtask

  // sender goes quiet until every read result is back
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  task automatic pick_cell_address(output logic [4:0] row, output logic [6:0] col);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      row = 5'($urandom_range(0, 31));
      col = 7'($urandom_range(0, 127));
    end else if (pick < 70) begin
      row = 5'((win_row + $urandom_range(0, 5)) % GRID_ROWS);
      col = 7'((win_col + $urandom_range(0, 7)) % GRID_COLS);
    end else begin
      row = 5'($urandom_range(0, GRID_ROWS - 1));
      col = 7'($urandom_range(0, GRID_COLS - 1));
    end
  endtask

  task automatic move_window();
    // origin often sits on an edge so patterns straddle the wrap
    win_row = $urandom_range(0, 1) ? GRID_ROWS - 3 : $urandom_range(0, GRID_ROWS - 1);
    win_col = $urandom_range(0, 1) ? GRID_COLS - 4 : $urandom_range(0, GRID_COLS - 1);
  endtask

  task automatic test_after_reset();
    send_cell_item(FUNC_READ, 5'd0, 7'd0, 1'b0);
    send_cell_item(FUNC_READ, 5'(GRID_ROWS - 1), 7'(GRID_COLS - 1), 1'b1);
    send_cell_item(FUNC_READ, 5'd31, 7'd127, 1'b0);
  endtask

  task automatic test_edges_and_ignored();
    send_cell_item(FUNC_WRITE, 5'd0, 7'd0, 1'b1);
    send_cell_item(FUNC_WRITE, 5'(GRID_ROWS - 1), 7'(GRID_COLS - 1), 1'b1);
    send_cell_item(FUNC_WRITE, 5'd0, 7'(GRID_COLS - 1), 1'b1);
    send_cell_item(FUNC_WRITE, 5'(GRID_ROWS), 7'd0, 1'b1);
    send_cell_item(FUNC_WRITE, 5'd0, 7'(GRID_COLS), 1'b1);
    send_cell_item(FUNC_WRITE, 5'd31, 7'd127, 1'b1);
    send_cell_item(FUNC_UNUSED, 5'(GRID_ROWS - 1), 7'd0, 1'b1);
    send_cell_item(FUNC_READ, 5'(GRID_ROWS - 1), 7'd0, 1'b0);
    send_cell_item(FUNC_READ, 5'd0, 7'd0, 1'b0);
    send_cell_item(FUNC_READ, 5'(GRID_ROWS - 1), 7'(GRID_COLS - 1), 1'b0);
    send_cell_item(FUNC_READ, 5'(GRID_ROWS), 7'd0, 1'b0);
    send_cell_item(FUNC_READ, 5'd0, 7'(GRID_COLS), 1'b0);
  endtask

  // three live cells around the corner give birth across both wraps
  task automatic test_corner_wrap();
    send_cell_item(FUNC_STEP, 5'd0, 7'd0, 1'b0);
    send_cell_item(FUNC_READ, 5'(GRID_ROWS - 1), 7'd0, 1'b0);
    send_cell_item(FUNC_READ, 5'd0, 7'd0, 1'b0);
    send_cell_item(FUNC_STEP, 5'd31, 7'd127, 1'b1);
    send_cell_item(FUNC_READ, 5'd0, 7'(GRID_COLS - 1), 1'b0);
    send_cell_item(FUNC_WRITE, 5'd0, 7'd0, 1'b0);
    send_cell_item(FUNC_STEP, 5'd0, 7'd0, 1'b0);
    send_cell_item(FUNC_READ, 5'd0, 7'd0, 1'b0);
    send_cell_item(FUNC_READ, 5'd1, 7'd1, 1'b0);
  endtask

  task automatic test_result_backpressure();
    logic [4:0] row;
    logic [6:0] col;
    send_max_gap = 0;
    recv_max_stall = 0;
    hold_cycles = 300;
    repeat (24) begin
      pick_cell_address(row, col);
      send_cell_item(FUNC_READ, row, col, 1'b0);
    end
    wait_for_drain();
  endtask

  task automatic test_random_life(int count, int gap_max, int stall_max);
    logic [4:0] row;
    logic [6:0] col;
    int         pick;
    send_max_gap = gap_max;
    recv_max_stall = stall_max;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) move_window();
      if (i % 110 == 109) wait_for_drain();
      pick = $urandom_range(0, 99);
      pick_cell_address(row, col);
      if (pick < 40)
        send_cell_item(FUNC_WRITE, row, col, 1'($urandom_range(0, 99) < 55));
      else if (pick < 85)
        send_cell_item(FUNC_READ, row, col, 1'($urandom_range(0, 1)));
      else if (pick < 93)
        send_cell_item(FUNC_STEP, row, col, 1'($urandom_range(0, 1)));
      else
        send_cell_item(FUNC_UNUSED, row, col, 1'($urandom_range(0, 1)));
    end
  endtask

  // receiver: random stall before each result, plus the long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready = 1'b0;
      end else if (ready_wait > 0) begin
        ready_wait--;
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        head_read = '{row: '0, col: '0, alive: 1'b0};
        report_mismatch("result beat with no read pending", head_read, out_cell_out);
      end else begin
        head_read = pending_reads.pop_front();
        if (out_cell_out !== head_read.alive)
          report_mismatch("cell_out", head_read, out_cell_out);
        reads_checked++;
      end
      ready_wait = $urandom_range(0, recv_max_stall);
    end
  end

  initial begin
    #5ms;
    $display("life_generation_step_tb failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_WRITE;
    in_row = '0;
    in_column = '0;
    in_cell_in = 1'b0;
    live_sel = 1'b0;
    mismatches = 0;
    items_sent = 0;
    reads_checked = 0;
    generations_run = 0;
    ready_wait = 0;
    hold_cycles = 0;
    send_max_gap = 17;
    recv_max_stall = 17;
    win_row = 0;
    win_col = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_after_reset();
    test_edges_and_ignored();
    test_corner_wrap();
    test_result_backpressure();
    test_random_life(450, 17, 17);
    test_random_life(450, 0, 0);
    test_random_life(250, 0, 17);
    test_random_life(250, 17, 0);

    wait_for_drain();
    repeat (40) @(posedge clk);
    $display("%0d beats sent, %0d reads checked, %0d generations advanced", items_sent,
             reads_checked, generations_run);
    $display("covered edge wrap, out-of-range addresses, unused func and result stalls");
    if (mismatches == 0)
      $display("life_generation_step_tb passed");
    else
      $display("life_generation_step_tb failed");
    $finish;
  end

endmodule
